>>> rtl/core/stwt_pkg.sv
// ----------------------------------------------------------------------------
// Session table package
// Command codes, register indexes, controller/datapath interface types.
// ----------------------------------------------------------------------------
package stwt_pkg;

  typedef enum logic [1:0] {
    CMD_OPEN  = 2'd0,
    CMD_CLOSE = 2'd1,
    CMD_CHECK = 2'd2
  } cmd_code_t;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_ROLES   = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  localparam logic [31:0] TIMEOUT_RESET = 32'(24 * 3600);
  localparam int          ROLE_SLOTS    = 8;

  typedef struct packed {
    logic capture;
    logic commit;
    logic scan_init;
    logic scan_step;
    logic evict;
  } dp_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
  } dp_stat_t;

  function automatic logic [3:0] role_of(input logic [31:0] roles,
                                         input logic [2:0]  user,
                                         input int          user_count);
    if (int'(user) >= user_count || int'(user) >= ROLE_SLOTS) begin
      return 4'd0;
    end
    return roles[{user, 2'b00} +: 4];
  endfunction

endpackage

>>> rtl/core/stwt_ctrl.sv
// ----------------------------------------------------------------------------
// Session table controller
// Sequences capture, resolve, eviction scan and commit of one transaction.
// ----------------------------------------------------------------------------
module stwt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  stwt_pkg::dp_stat_t stat,
  output stwt_pkg::dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESOLVE,
    S_SCAN,
    S_EVICT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        if (stat.need_scan) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_EVICT;
        end
      end
      S_EVICT: begin
        cmd.evict = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

>>> rtl/core/stwt_dp.sv
// ----------------------------------------------------------------------------
// Session table datapath
// Slot store, per-slot match/age lanes, eviction scan and result register.
// ----------------------------------------------------------------------------
module stwt_dp #(
  parameter int SESSION_SLOTS = 8,
  parameter int USER_COUNT    = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  stwt_pkg::dp_cmd_t  cmd,
  output stwt_pkg::dp_stat_t stat,
  input  logic [31:0]        timeout,
  input  logic [31:0]        roles,
  input  logic [1:0]         in_cmd,
  input  logic [63:0]        in_token_high,
  input  logic [63:0]        in_token_low,
  input  logic [2:0]         in_user_index,
  input  logic [31:0]        in_now_seconds,
  output logic               out_valid,
  output logic               out_status,
  output logic [3:0]         out_user_role,
  output logic [2:0]         out_slot_used
);

  localparam int SLOT_W = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SESSION_SLOTS - 1);

  // slot store
  logic [SESSION_SLOTS-1:0] valid_r;
  logic [63:0]              tok_hi_r  [SESSION_SLOTS];
  logic [63:0]              tok_lo_r  [SESSION_SLOTS];
  logic [2:0]               user_r    [SESSION_SLOTS];
  logic [31:0]              seen_r    [SESSION_SLOTS];

  // captured transaction
  logic [1:0]               cmd_r;
  logic [63:0]              in_hi_r;
  logic [63:0]              in_lo_r;
  logic [2:0]               in_user_r;
  logic [31:0]              now_r;

  // lane results
  logic [31:0]              age_c     [SESSION_SLOTS];
  logic [SESSION_SLOTS-1:0] match_c, exp_c, free_c;
  logic [31:0]              age_r     [SESSION_SLOTS];
  logic [SESSION_SLOTS-1:0] match_r, exp_r, free_r;

  // eviction scan
  logic [SLOT_W-1:0]        scan_idx_r;
  logic [SLOT_W-1:0]        best_idx_r;
  logic [31:0]              best_age_r;

  // result
  logic                     out_valid_r;
  logic                     out_status_r;
  logic [3:0]               out_user_role_r;
  logic [2:0]               out_slot_r;

  logic [SLOT_W-1:0]        free_idx, match_idx, wr_idx;
  logic                     wr_open, refresh;
  logic [SESSION_SLOTS-1:0] clr_mask;
  logic                     res_status;
  logic [3:0]               res_role;
  logic [SLOT_W-1:0]        res_slot;
  logic [SLOT_W+2:0]        slot_ext;

  always_comb begin
    for (int i = 0; i < SESSION_SLOTS; i++) begin
      age_c[i]   = in_now_seconds - seen_r[i];
      match_c[i] = valid_r[i] && (tok_hi_r[i] == in_token_high)
                              && (tok_lo_r[i] == in_token_low);
      exp_c[i]   = age_c[i] > timeout;
      free_c[i]  = !valid_r[i] || exp_c[i];
    end
  end

  always_comb begin
    free_idx  = '0;
    match_idx = '0;
    for (int i = SESSION_SLOTS - 1; i >= 0; i--) begin
      if (free_r[i]) begin
        free_idx = SLOT_W'(i);
      end
      if (match_r[i]) begin
        match_idx = SLOT_W'(i);
      end
    end
  end

  assign stat.need_scan = (cmd_r == stwt_pkg::CMD_OPEN) && !(|free_r);
  assign stat.scan_last = (scan_idx_r == LAST_SLOT);

  always_comb begin
    wr_open    = 1'b0;
    wr_idx     = free_idx;
    refresh    = 1'b0;
    clr_mask   = '0;
    res_status = stwt_pkg::STATUS_OK;
    res_role   = 4'd0;
    res_slot   = '0;
    if (cmd.evict) begin
      wr_open  = 1'b1;
      wr_idx   = best_idx_r;
      res_role = stwt_pkg::role_of(roles, in_user_r, USER_COUNT);
      res_slot = best_idx_r;
    end else if (cmd.commit) begin
      case (cmd_r)
        stwt_pkg::CMD_OPEN: begin
          wr_open  = 1'b1;
          res_role = stwt_pkg::role_of(roles, in_user_r, USER_COUNT);
          res_slot = free_idx;
        end
        stwt_pkg::CMD_CLOSE: begin
          clr_mask = match_r;
        end
        stwt_pkg::CMD_CHECK: begin
          res_status = stwt_pkg::STATUS_FAIL;
          if (|match_r) begin
            if (exp_r[match_idx]) begin
              clr_mask[match_idx] = 1'b1;
            end else begin
              refresh    = 1'b1;
              res_status = stwt_pkg::STATUS_OK;
              res_role   = stwt_pkg::role_of(roles, user_r[match_idx], USER_COUNT);
              res_slot   = match_idx;
            end
          end
        end
        default: begin
          res_status = stwt_pkg::STATUS_FAIL;
        end
      endcase
    end
    slot_ext = {3'b000, res_slot};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= (valid_r & ~clr_mask)
                   | (wr_open ? (SESSION_SLOTS'(1) << wr_idx) : '0);
      out_valid_r <= cmd.commit || cmd.evict;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r     <= in_cmd;
      in_hi_r   <= in_token_high;
      in_lo_r   <= in_token_low;
      in_user_r <= in_user_index;
      now_r     <= in_now_seconds;
      match_r   <= match_c;
      exp_r     <= exp_c;
      free_r    <= free_c;
      for (int i = 0; i < SESSION_SLOTS; i++) begin
        age_r[i] <= age_c[i];
      end
    end
    if (cmd.scan_init) begin
      scan_idx_r <= '0;
      best_idx_r <= '0;
      best_age_r <= age_r[0];
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + SLOT_W'(1);
      if (age_r[scan_idx_r] > best_age_r) begin
        best_idx_r <= scan_idx_r;
        best_age_r <= age_r[scan_idx_r];
      end
    end
    if (wr_open) begin
      tok_hi_r[wr_idx] <= in_hi_r;
      tok_lo_r[wr_idx] <= in_lo_r;
      user_r[wr_idx]   <= in_user_r;
      seen_r[wr_idx]   <= now_r;
    end else if (refresh) begin
      seen_r[match_idx] <= now_r;
    end
    if (cmd.commit || cmd.evict) begin
      out_status_r    <= res_status;
      out_user_role_r <= res_role;
      out_slot_r      <= slot_ext[2:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_user_role = out_user_role_r;
  assign out_slot_used = out_slot_r;

endmodule

>>> rtl/core/session_table_with_timeout_top.sv
// ----------------------------------------------------------------------------
// Session table with idle timeout - top level
// Start is accepted only in idle; the result strobe is registered from the
// resolve or evict state. An open that must evict walks the captured age
// registers one slot a cycle, then writes the oldest slot.
// Results cannot be stalled. Synchronous reset empties every slot and loads
// timeout 86400 and roles 0; no clearing pass.
// ----------------------------------------------------------------------------
module session_table_with_timeout_top #(
  parameter int SESSION_SLOTS = 8,
  parameter int USER_COUNT    = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [63:0] in_token_high,
  input  logic [63:0] in_token_low,
  input  logic [2:0]  in_user_index,
  input  logic [31:0] in_now_seconds,
  output logic        out_valid,
  output logic        out_status,
  output logic [3:0]  out_user_role,
  output logic [2:0]  out_slot_used,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  stwt_pkg::dp_cmd_t  dp_cmd;
  stwt_pkg::dp_stat_t dp_stat;
  logic [31:0]        timeout_r;
  logic [31:0]        roles_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= stwt_pkg::TIMEOUT_RESET;
      roles_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        stwt_pkg::CFG_TIMEOUT: timeout_r <= cfg_data;
        stwt_pkg::CFG_ROLES:   roles_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  stwt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (dp_stat),
    .cmd   (dp_cmd)
  );

  stwt_dp #(
    .SESSION_SLOTS (SESSION_SLOTS),
    .USER_COUNT    (USER_COUNT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (dp_cmd),
    .stat           (dp_stat),
    .timeout        (timeout_r),
    .roles          (roles_r),
    .in_cmd         (in_cmd),
    .in_token_high  (in_token_high),
    .in_token_low   (in_token_low),
    .in_user_index  (in_user_index),
    .in_now_seconds (in_now_seconds),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_user_role  (out_user_role),
    .out_slot_used  (out_slot_used)
  );

endmodule
